/* rtl/snx_pkg.sv */
// snx_pkg: constants, types and helper functions for the 2d simplex noise pipeline
// no dependencies; imported by snx_corner and simplex_noise_2d_eval
package snx_pkg;

    // internal fixed-point format of offsets and falloff values
    localparam int IQ = 24;

    // skew and unskew factors
    localparam logic [27:0] F2_Q28 = 28'd98254196;
    localparam logic [27:0] G2_Q28 = 28'd56727087;
    localparam logic [21:0] G2_Q24 = 22'd3545443;

    // falloff correction coefficients
    localparam longint CORR_C1 = 64'sd30078913;
    localparam longint CORR_C2 = 64'sd14323292;

    // permutation polynomial and modulus
    localparam logic [14:0] PERM_A  = 15'd34;
    localparam logic [8:0]  MOD_P   = 9'd289;
    localparam logic [5:0]  GRAD_D  = 6'd41;
    localparam int          NGRAD   = 41;

    // reciprocals for division by constants
    localparam logic [26:0] M289_35 = 27'd118891828;
    localparam logic [34:0] OFF289  = 35'd9697230848;
    localparam logic [15:0] M289_24 = 16'd58052;
    localparam logic [31:0] M82_38  = 32'd3352169596;
    localparam logic [31:0] OFF82   = 32'd1375731712;
    localparam logic [6:0]  DIV_G   = 7'd82;

    // pipeline depth of one corner unit
    localparam int CORNER_LAT = 10;

    typedef logic signed [29:0] ofs_t;

    // (34*v + 1)*v for v up to 577
    function automatic logic [24:0] perm_mul(logic [9:0] v);
        logic [14:0] a;
        a = 15'(v) * PERM_A + 15'd1;
        return 25'(a) * 25'(v);
    endfunction

    // x mod 41 for x below 289
    function automatic logic [5:0] mod41(logic [8:0] x);
        logic [8:0] r;
        r = x;
        for (int i = 0; i < 7; i++)
        begin
            if (r >= 9'(GRAD_D))
            begin
                r = r - 9'(GRAD_D);
            end
        end
        return 6'(r);
    endfunction

    // diamond gradient components for hash residue r
    function automatic int grad_a(int r);
        int n;
        int s;
        int fl;
        n  = 2 * r - 41;
        s  = 2 * n + 41;
        fl = (s < 0) ? -1 : ((s < 82) ? 0 : 1);
        return 2 * n - 82 * fl;
    endfunction

    function automatic int grad_h(int r);
        int n;
        n = 2 * r - 41;
        return 2 * ((n < 0) ? -n : n) - 41;
    endfunction

    // inverse-root correction, evaluated only for constant tables
    function automatic longint corr_of(int r);
        longint a;
        longint h;
        a = longint'(grad_a(r));
        h = longint'(grad_h(r));
        return CORR_C1 - (CORR_C2 * (a * a + h * h)) / 64'sd6724;
    endfunction

endpackage

/* rtl/snx_corner.sv */
// snx_corner: per-corner hash, gradient, falloff and dot product pipeline
// depends on snx_pkg; instantiated three times by simplex_noise_2d_eval
module snx_corner
    import snx_pkg::*;
(
    input  logic                clk,
    input  logic                en,
    input  ofs_t                ox,
    input  ofs_t                oy,
    input  logic [9:0]          vx,
    input  logic [9:0]          vy,
    output logic [21:0]         m,
    output logic signed [26:0]  g
);

    // constant gradient and correction tables
    logic signed [7:0] ga_tab [NGRAD];
    logic signed [7:0] gh_tab [NGRAD];
    logic [24:0]       corr_tab [NGRAD];

    for (genvar k = 0; k < NGRAD; k++)
    begin : g_tab
        assign ga_tab[k]   = 8'(grad_a(k));
        assign gh_tab[k]   = 8'(grad_h(k));
        assign corr_tab[k] = 25'(corr_of(k));
    end

    // c1: inner permutation product, squared distance
    logic [24:0]        p1_reg;
    logic [60:0]        sq_reg;
    ofs_t               ox1_reg, oy1_reg;
    logic [9:0]         vx1_reg;
    logic signed [59:0] sqx, sqy;

    assign sqx = ox * ox;
    assign sqy = oy * oy;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg  <= perm_mul(vy);
            sq_reg  <= 61'($unsigned(sqx)) + 61'($unsigned(sqy));
            ox1_reg <= ox;
            oy1_reg <= oy;
            vx1_reg <= vx;
        end
    end

    // c2: reciprocal product for mod 289, radial falloff base
    logic [40:0]  pm2_reg;
    logic [24:0]  p2b_reg;
    logic [23:0]  t2_reg;
    ofs_t         ox2_reg, oy2_reg;
    logic [9:0]   vx2_reg;
    logic [36:0]  rsq;
    logic [23:0]  t_next;

    assign rsq    = sq_reg[60:24];
    assign t_next = (rsq >= 37'd8388608) ? 24'd0 : 24'(37'd8388608 - rsq);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pm2_reg <= 41'(p1_reg) * 41'(M289_24);
            p2b_reg <= p1_reg;
            t2_reg  <= t_next;
            ox2_reg <= ox1_reg;
            oy2_reg <= oy1_reg;
            vx2_reg <= vx1_reg;
        end
    end

    // c3: finish inner hash, add x index, square falloff
    logic [9:0]  v3_reg;
    logic [47:0] tt3_reg;
    ofs_t        ox3_reg, oy3_reg;
    logic [16:0] q3;
    logic [25:0] r3;
    logic [9:0]  r3s;
    logic [8:0]  h1;

    assign q3  = pm2_reg[40:24];
    assign r3  = 26'(p2b_reg) - 26'(q3) * 26'(MOD_P);
    assign r3s = r3[9:0];
    assign h1  = (r3s >= 10'(MOD_P)) ? 9'(r3s - 10'(MOD_P)) : r3s[8:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v3_reg  <= 10'(h1) + vx2_reg;
            tt3_reg <= 48'(t2_reg) * 48'(t2_reg);
            ox3_reg <= ox2_reg;
            oy3_reg <= oy2_reg;
        end
    end

    // c4: outer permutation product, fourth power
    logic [24:0] p4_reg;
    logic [47:0] tsq4_reg;
    ofs_t        ox4_reg, oy4_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p4_reg   <= perm_mul(v3_reg);
            tsq4_reg <= 48'(tt3_reg[47:24]) * 48'(tt3_reg[47:24]);
            ox4_reg  <= ox3_reg;
            oy4_reg  <= oy3_reg;
        end
    end

    // c5: reciprocal product for outer mod 289
    logic [40:0] pm5_reg;
    logic [24:0] p5_reg;
    logic [20:0] t4_5_reg;
    ofs_t        ox5_reg, oy5_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pm5_reg  <= 41'(p4_reg) * 41'(M289_24);
            p5_reg   <= p4_reg;
            t4_5_reg <= tsq4_reg[44:24];
            ox5_reg  <= ox4_reg;
            oy5_reg  <= oy4_reg;
        end
    end

    // c6: final corner hash
    logic [8:0]  hsh6_reg;
    logic [20:0] t4_6_reg;
    ofs_t        ox6_reg, oy6_reg;
    logic [16:0] q6;
    logic [25:0] r6;
    logic [9:0]  r6s;

    assign q6  = pm5_reg[40:24];
    assign r6  = 26'(p5_reg) - 26'(q6) * 26'(MOD_P);
    assign r6s = r6[9:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hsh6_reg <= (r6s >= 10'(MOD_P)) ? 9'(r6s - 10'(MOD_P)) : r6s[8:0];
            t4_6_reg <= t4_5_reg;
            ox6_reg  <= ox5_reg;
            oy6_reg  <= oy5_reg;
        end
    end

    // c7: gradient and correction lookup
    logic signed [7:0] ga7_reg, gh7_reg;
    logic [24:0]       corr7_reg;
    logic [20:0]       t4_7_reg;
    ofs_t              ox7_reg, oy7_reg;
    logic [5:0]        r41;

    assign r41 = mod41(hsh6_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ga7_reg   <= ga_tab[r41];
            gh7_reg   <= gh_tab[r41];
            corr7_reg <= corr_tab[r41];
            t4_7_reg  <= t4_6_reg;
            ox7_reg   <= ox6_reg;
            oy7_reg   <= oy6_reg;
        end
    end

    // c8: corrected falloff, gradient dot product
    logic [45:0]        mp8_reg;
    logic signed [31:0] dot8_reg;
    logic signed [37:0] dax, dhy;
    logic signed [38:0] dot;

    assign dax = ga7_reg * ox7_reg;
    assign dhy = gh7_reg * oy7_reg;
    assign dot = 39'(dax) + 39'(dhy);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mp8_reg  <= 46'(t4_7_reg) * 46'(corr7_reg);
            // dot only matters inside the falloff radius, where it stays small
            dot8_reg <= (t4_7_reg == 21'd0) ? 32'sd0 : 32'(dot);
        end
    end

    // c9: reciprocal product for floor division by 82
    logic [21:0] m9_reg;
    logic [31:0] u9_reg;
    logic [63:0] qm9_reg;
    logic [31:0] u9;

    assign u9 = $unsigned(dot8_reg) + OFF82;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m9_reg  <= mp8_reg[45:24];
            u9_reg  <= u9;
            qm9_reg <= 64'(u9) * 64'(M82_38);
        end
    end

    // c10: quotient correction and offset removal
    logic [21:0]        m_reg;
    logic signed [26:0] g_reg;
    logic [25:0]        q10;
    logic [32:0]        r10;
    logic [25:0]        qf;

    assign q10 = qm9_reg[63:38];
    assign r10 = 33'(u9_reg) - 33'(q10) * 33'(DIV_G);
    assign qf  = (r10 >= 33'(DIV_G)) ? q10 + 26'd1 : q10;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg <= m9_reg;
            g_reg <= $signed({1'b0, qf}) - 27'sd16777216;
        end
    end

    assign m = m_reg;
    assign g = g_reg;

endmodule

/* rtl/simplex_noise_2d_eval.sv */
// simplex_noise_2d_eval: 2d simplex noise evaluator, fully pipelined
// depends on snx_pkg and snx_corner
//
// usage:
//   input channel in_valid/in_ready carries one coordinate pair (coord_x,
//   coord_y) in signed fixed point with FRAC_BITS fraction bits per
//   transaction. output channel out_valid/out_ready carries one noise_value
//   (signed Q1.15, saturated) per input transaction, in input order.
//   the path from input transaction to out_valid runs through five front
//   stages (skew, cell index, unskew and mod 289, offsets, corner setup),
//   ten stages of the per-corner unit, and three back stages (weighting,
//   scaling, saturation into the output register).
//   throughput is one transaction per cycle when not stalled; every
//   stage holds at most one item and the whole pipeline advances together.
//   when out_ready is low while a result is shown, the pipeline freezes and
//   in_ready drops; no item is lost or repeated. bubbles are not squeezed
//   out during such a stall.
//   reset clears all valid bits; payload registers are not reset. the block
//   keeps no state between transactions.
module simplex_noise_2d_eval
    import snx_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [31:0]  coord_x,
    input  logic signed [31:0]  coord_y,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [15:0]  noise_value
);

    localparam int NSTG = 5 + CORNER_LAT + 3;

    // valid bits and global advance
    logic [NSTG-1:0] vld_reg;
    logic            en;

    assign en        = !vld_reg[NSTG-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = vld_reg[NSTG-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NSTG-2:0], in_valid};
        end
    end

    // s1: skew product
    logic signed [31:0] px1_reg, py1_reg;
    logic signed [61:0] skp1_reg;
    logic signed [32:0] sxy;

    assign sxy = 33'(coord_x) + 33'(coord_y);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px1_reg  <= coord_x;
            py1_reg  <= coord_y;
            skp1_reg <= 62'(sxy) * 62'($signed({1'b0, F2_Q28}));
        end
    end

    // s2: cell index
    logic signed [31:0] px2_reg, py2_reg;
    logic signed [33:0] ci2_reg, cj2_reg;
    logic signed [33:0] skew, xs, ys;

    assign skew = skp1_reg[61:28];
    assign xs   = 34'(px1_reg) + skew;
    assign ys   = 34'(py1_reg) + skew;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px2_reg <= px1_reg;
            py2_reg <= py1_reg;
            ci2_reg <= xs >>> FRAC_BITS;
            cj2_reg <= ys >>> FRAC_BITS;
        end
    end

    // s3: unskew product and reciprocal products for the cell index mod 289
    logic signed [31:0] px3_reg, py3_reg;
    logic signed [33:0] ci3_reg, cj3_reg;
    logic signed [63:0] unp3_reg;
    logic [34:0]        ui3_reg, uj3_reg;
    logic [61:0]        mpi3_reg, mpj3_reg;
    logic signed [34:0] cs;
    logic [34:0]        ui, uj;

    assign cs = 35'(ci2_reg) + 35'(cj2_reg);
    assign ui = $unsigned(35'(ci2_reg)) + OFF289;
    assign uj = $unsigned(35'(cj2_reg)) + OFF289;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px3_reg  <= px2_reg;
            py3_reg  <= py2_reg;
            ci3_reg  <= ci2_reg;
            cj3_reg  <= cj2_reg;
            unp3_reg <= 64'(cs) * 64'($signed({1'b0, G2_Q28}));
            ui3_reg  <= ui;
            uj3_reg  <= uj;
            mpi3_reg <= 62'(ui) * 62'(M289_35);
            mpj3_reg <= 62'(uj) * 62'(M289_35);
        end
    end

    // s4: first corner offset, raw residues
    ofs_t               ox4_reg, oy4_reg;
    logic [9:0]         ri4_reg, rj4_reg;
    logic [26:0]        qi, qj;
    logic [35:0]        ri, rj;
    logic signed [63:0] dxo, dyo, ox0, oy0;

    assign qi  = mpi3_reg[61:35];
    assign qj  = mpj3_reg[61:35];
    assign ri  = 36'(ui3_reg) - 36'(qi) * 36'(MOD_P);
    assign rj  = 36'(uj3_reg) - 36'(qj) * 36'(MOD_P);
    assign dxo = (64'(px3_reg) - (64'(ci3_reg) <<< FRAC_BITS)) <<< (IQ - FRAC_BITS);
    assign dyo = (64'(py3_reg) - (64'(cj3_reg) <<< FRAC_BITS)) <<< (IQ - FRAC_BITS);
    assign ox0 = dxo + (unp3_reg >>> (28 - IQ));
    assign oy0 = dyo + (unp3_reg >>> (28 - IQ));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ox4_reg <= ox0[29:0];
            oy4_reg <= oy0[29:0];
            ri4_reg <= ri[9:0];
            rj4_reg <= rj[9:0];
        end
    end

    // s5: middle corner choice, corner offsets and hash arguments
    ofs_t       ox5_reg [3];
    ofs_t       oy5_reg [3];
    logic [9:0] vx5_reg [3];
    logic [9:0] vy5_reg [3];
    logic [8:0] mi, mj;
    logic       stepx;
    ofs_t       one_q, g2, g2x2;

    assign mi    = (ri4_reg >= 10'(MOD_P)) ? 9'(ri4_reg - 10'(MOD_P)) : ri4_reg[8:0];
    assign mj    = (rj4_reg >= 10'(MOD_P)) ? 9'(rj4_reg - 10'(MOD_P)) : rj4_reg[8:0];
    assign stepx = ox4_reg > oy4_reg;
    assign one_q = 30'sd16777216;
    assign g2    = $signed(30'(G2_Q24));
    assign g2x2  = $signed(30'(G2_Q24) << 1);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ox5_reg[0] <= ox4_reg;
            oy5_reg[0] <= oy4_reg;
            ox5_reg[1] <= ox4_reg + g2 - (stepx ? one_q : 30'sd0);
            oy5_reg[1] <= oy4_reg + g2 - (stepx ? 30'sd0 : one_q);
            ox5_reg[2] <= ox4_reg + g2x2 - one_q;
            oy5_reg[2] <= oy4_reg + g2x2 - one_q;
            vx5_reg[0] <= 10'(mi);
            vy5_reg[0] <= 10'(mj);
            vx5_reg[1] <= 10'(mi) + 10'(stepx);
            vy5_reg[1] <= 10'(mj) + 10'(!stepx);
            vx5_reg[2] <= 10'(mi) + 10'd1;
            vy5_reg[2] <= 10'(mj) + 10'd1;
        end
    end

    // corner units
    logic [21:0]        cm [3];
    logic signed [26:0] cg [3];

    for (genvar c = 0; c < 3; c++)
    begin : g_corner
        snx_corner u_corner
        (
            .clk (clk),
            .en  (en),
            .ox  (ox5_reg[c]),
            .oy  (oy5_reg[c]),
            .vx  (vx5_reg[c]),
            .vy  (vy5_reg[c]),
            .m   (cm[c]),
            .g   (cg[c])
        );
    end

    // s16: weighted corner contributions
    logic signed [49:0] mg_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                mg_reg[c] <= $signed({1'b0, cm[c]}) * cg[c];
            end
        end
    end

    // s17: sum and scale by 130
    logic signed [59:0] sc_reg;
    logic signed [59:0] sum;

    assign sum = 60'(mg_reg[0]) + 60'(mg_reg[1]) + 60'(mg_reg[2]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sc_reg <= (sum <<< 7) + (sum <<< 1);
        end
    end

    // s18: conversion to q1.15 with saturation
    logic signed [15:0] out_reg;
    logic signed [26:0] res;

    assign res = sc_reg[59:33];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (res > 27'sd32767)
            begin
                out_reg <= 16'sh7FFF;
            end
            else if (res < -27'sd32768)
            begin
                out_reg <= 16'sh8000;
            end
            else
            begin
                out_reg <= res[15:0];
            end
        end
    end

    assign noise_value = out_reg;

endmodule

/* tb/sv/simplex_noise_2d_eval_test.sv */
// simplex_noise_2d_eval_test: self-checking testbench for the 2d simplex noise evaluator
// depends on simplex_noise_2d_eval; predicts each result from the coordinate pair
`timescale 1ns / 100ps

module simplex_noise_2d_eval_test;

    localparam int FRAC = 16;
    localparam int RAND_ITEMS = 1530;
    localparam int STALL_LIMIT = 5000;
    localparam int LATENCY = 18;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic               out_valid;
    logic               out_ready;
    logic signed [15:0] noise_value;

    typedef struct packed
    {
        logic signed [31:0] x;
        logic signed [31:0] y;
    } coord_t;

    coord_t             pending_coords[$];
    logic signed [15:0] noise_expected[$];
    int                 mismatches;
    int                 idle_cycles;
    bit                 stim_done;
    bit                 hold_receiver;
    bit                 timed_out;
    bit                 in_ready_seen;

    simplex_noise_2d_eval #(.FRAC_BITS(FRAC)) u_dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .coord_x(coord_x),
        .coord_y(coord_y),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .noise_value(noise_value)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // floor division
    function automatic longint floor_div(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && ((a < 0) != (b < 0)))
        begin
            q = q - 1;
        end
        return q;
    endfunction

    function automatic longint wrap289(longint a);
        longint r;
        r = a % 289;
        if (r < 0)
        begin
            r = r + 289;
        end
        return r;
    endfunction

    function automatic longint hash_step(longint v);
        return wrap289((34 * v + 1) * v);
    endfunction

    // expected noise for one coordinate pair
    function automatic logic signed [15:0] noise_of(logic signed [31:0] cx,
                                                    logic signed [31:0] cy);
        longint one_f;
        longint one_q;
        longint up;
        longint px;
        longint py;
        longint skew;
        longint ci;
        longint cj;
        longint unskew;
        longint ox[3];
        longint oy[3];
        longint sx;
        longint sy;
        longint mi;
        longint mj;
        longint acc;
        longint res;
        longint ax;
        longint ay;
        longint hv;
        longint n;
        longint fl;
        longint ga;
        longint gh;
        longint d;
        longint t;
        longint corr;
        longint m;
        longint g;
        one_f = longint'(1) << FRAC;
        one_q = longint'(1) << 24;
        up = longint'(1) << (24 - FRAC);
        px = longint'(cx);
        py = longint'(cy);
        skew = floor_div((px + py) * 98254196, longint'(1) << 28);
        ci = floor_div(px + skew, one_f);
        cj = floor_div(py + skew, one_f);
        unskew = floor_div((ci + cj) * 56727087, 16);
        ox[0] = (px - ci * one_f) * up + unskew;
        oy[0] = (py - cj * one_f) * up + unskew;
        sx = (ox[0] > oy[0]) ? 1 : 0;
        sy = 1 - sx;
        ox[1] = ox[0] + 3545443 - sx * one_q;
        oy[1] = oy[0] + 3545443 - sy * one_q;
        ox[2] = ox[0] + 2 * 3545443 - one_q;
        oy[2] = oy[0] + 2 * 3545443 - one_q;
        mi = wrap289(ci);
        mj = wrap289(cj);
        acc = 0;
        for (int c = 0; c < 3; c++)
        begin
            ax = (c == 0) ? 0 : ((c == 1) ? sx : 1);
            ay = (c == 0) ? 0 : ((c == 1) ? sy : 1);
            hv = hash_step(hash_step(mj + ay) + mi + ax);
            n = 2 * (hv % 41) - 41;
            fl = floor_div(2 * n + 41, 82);
            ga = 2 * n - 82 * fl;
            gh = 2 * ((n < 0) ? -n : n) - 41;
            d = (ox[c] * ox[c] + oy[c] * oy[c]) >>> 24;
            t = (one_q >>> 1) - d;
            if (t < 0)
            begin
                t = 0;
            end
            t = (t * t) >>> 24;
            t = (t * t) >>> 24;
            corr = 30078913 - (14323292 * (ga * ga + gh * gh)) / 6724;
            m = (t * corr) >>> 24;
            g = floor_div(ga * ox[c] + gh * oy[c], 82);
            acc = acc + m * g;
        end
        res = floor_div(acc * 130, longint'(1) << 33);
        if (res > 32767)
        begin
            res = 32767;
        end
        if (res < -32768)
        begin
            res = -32768;
        end
        return 16'(res);
    endfunction

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'($urandom);
            1: return 32'($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000;
            2: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom)};
            3: return $urandom_range(0, 1) ? 32'sh7fff_ff00 + 32'($urandom_range(0, 255))
                                           : 32'sh8000_0000 + 32'($urandom_range(0, 255));
            default: return 32'($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
        endcase
    endfunction

    task automatic push_coord(logic signed [31:0] x, logic signed [31:0] y);
        coord_t c;
        c.x = x;
        c.y = y;
        pending_coords.push_back(c);
    endtask

    // driver: one transaction per queue entry, random gap after each
    initial
    begin
        in_valid = 1'b0;
        coord_x = '0;
        coord_y = '0;
    end

    always @(negedge clk)
    begin : driver
        static int gap = 0;
        if (rst_n)
        begin
            if (in_valid && in_ready_seen)
            begin
                noise_expected.push_back(noise_of(coord_x, coord_y));
            end
            if (!(in_valid && !in_ready_seen))
            begin
                if (gap > 0)
                begin
                    gap = gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_coords.size() > 0)
                begin
                    coord_t c;
                    c = pending_coords.pop_front();
                    coord_x <= c.x;
                    coord_y <= c.y;
                    in_valid <= 1'b1;
                    gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 5) : 0;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // acceptance seen at the rising edge
    always @(posedge clk)
    begin
        in_ready_seen <= in_valid && in_ready;
    end

    // monitor: compare each result with the oldest expectation
    always @(posedge clk)
    begin : monitor
        logic signed [15:0] want;
        if (rst_n && out_valid && out_ready)
        begin
            if (noise_expected.size() == 0)
            begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                begin
                    $display("unexpected result %0d", noise_value);
                end
            end
            else
            begin
                want = noise_expected.pop_front();
                if (noise_value !== want)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                    begin
                        $display("noise_value mismatch: expected %0d got %0d",
                                 want, noise_value);
                    end
                end
            end
        end
    end

    // receiver stalls
    initial
    begin
        out_ready = 1'b0;
    end

    always @(negedge clk)
    begin : receiver
        static int wait_left = 0;
        if (hold_receiver)
        begin
            out_ready <= 1'b0;
        end
        else if (wait_left > 0)
        begin
            wait_left = wait_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if (out_valid && out_ready)
            begin
                wait_left = $urandom_range(0, 2) == 0 ? $urandom_range(0, 5) : 0;
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT && !timed_out)
            begin
                timed_out = 1'b1;
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (pending_coords.size() > 0 || in_valid || noise_expected.size() > 0
               || in_ready_seen)
        begin
            @(posedge clk);
        end
    endtask

    // stimulus and end of run
    initial
    begin
        mismatches = 0;
        idle_cycles = 0;
        stim_done = 1'b0;
        hold_receiver = 1'b0;
        timed_out = 1'b0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, origin, lattice points and both corner orders
        push_coord(32'sh0000_0000, 32'sh0000_0000);
        push_coord(32'sh7fff_ffff, 32'sh7fff_ffff);
        push_coord(32'sh8000_0000, 32'sh8000_0000);
        push_coord(32'sh7fff_ffff, 32'sh8000_0000);
        push_coord(32'sh8000_0000, 32'sh7fff_ffff);
        push_coord(32'shffff_ffff, 32'shffff_ffff);
        push_coord(32'sh0001_0000, 32'sh0000_0000);
        push_coord(32'sh0000_0000, 32'sh0001_0000);
        push_coord(32'sh0000_8000, 32'sh0000_4000);
        push_coord(32'sh0000_4000, 32'sh0000_8000);
        push_coord(32'sh0000_8000, 32'sh0000_8000);
        push_coord(32'shffff_8000, 32'sh0000_3000);
        push_coord(32'sh0121_0000, 32'shfedf_0000);
        push_coord(32'sh5555_5555, 32'shaaaa_aaaa);
        push_coord(32'shaaaa_aaaa, 32'sh5555_5555);
        push_coord(32'sh0000_0001, 32'shffff_ffff);
        for (int i = 0; i < 8; i++)
        begin
            push_coord(32'sh0000_2000 * i, 32'sh0000_1800 * (7 - i));
        end
        wait_drained();

        // receiver held off while the sender keeps offering
        hold_receiver = 1'b1;
        for (int i = 0; i < 60; i++)
        begin
            push_coord(rand_coord(), rand_coord());
        end
        repeat (80) @(posedge clk);
        hold_receiver = 1'b0;
        wait_drained();

        // random coordinates
        for (int i = 0; i < RAND_ITEMS - 60; i++)
        begin
            push_coord(rand_coord(), rand_coord());
        end
        wait_drained();
        stim_done = 1'b1;
        repeat (LATENCY + 10) @(posedge clk);

        if (mismatches == 0 && noise_expected.size() == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
